[rtl/core/gtc_pkg.sv]
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types and constants for the graph tree check block.
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_CHECK,
    ST_POP,
    ST_DONE
  } state_t;

endpackage

[rtl/core/gtc_ram.sv]
// ----------------------------------------------------------------------------
// gtc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gtc_ram import gtc_pkg::*; #(
  parameter int DEPTH = MAX_NODES_DEF,
  parameter int WIDTH = 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/graph_tree_check.sv]
// ----------------------------------------------------------------------------
// graph_tree_check
// Loads an adjacency matrix one cell per transfer, then walks it depth first
// from node 0 and reports whether the graph is a tree.
// ----------------------------------------------------------------------------
// Throughput: one matrix cell per cycle while loading.
// Walk: after the last cell, ST_INIT, then per probed column ST_SCAN reads the
//   matrix RAM and ST_CHECK uses the data; ST_POP returns to the parent frame.
// Input is held off during the walk and while a result waits for the output register.
// Reset: rst clears control state, visited marks and node_count (to 1);
//   matrix and stack RAMs are not cleared.
module graph_tree_check import gtc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,    // node_count
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,     // row[5:0], column[11:6], edge_present[12]
  input  logic               s_tlast,     // last_cell
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata      // is_tree[0]
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int IW   = (NW + 1 > COUNT_W) ? NW + 1 : COUNT_W;
  localparam int FW   = 3 * NW + 2;
  localparam int CAW  = 2 * NW;
  localparam int CDEP = 1 << CAW;

  state_t state, state_next;

  logic [COUNT_W-1:0] node_count;
  logic [NW:0]        n_q;
  logic [NW:0]        used_n;
  logic [NW:0]        sp;
  logic [NW:0]        seen;
  logic [MAX_NODES-1:0] visited;
  logic [NW-1:0]      cur_node;
  logic [NW-1:0]      cur_parent;
  logic               cur_hasp;
  logic [NW:0]        cur_next;
  logic [NW-1:0]      col_q;
  logic               result_q;
  logic               out_flag;

  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic               in_edge;
  logic               in_fire;
  logic               in_store;

  logic               cell_we;
  logic [CAW-1:0]     cell_wa;
  logic [CAW-1:0]     cell_ra;
  logic [0:0]         cell_rd;

  logic               stk_we;
  logic [NW-1:0]      stk_wa;
  logic [NW-1:0]      stk_ra;
  logic [FW-1:0]      stk_wd;
  logic [FW-1:0]      stk_rd;

  logic               scan_end;
  logic               hit;
  logic               cycle_found;
  logic               out_free;

  assign in_row  = s_tdata[ROW_W-1:0];
  assign in_col  = s_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_edge = s_tdata[ROW_W+COL_W];

  assign cfg_ready = !rst;
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign in_fire   = s_tvalid && s_tready;
  assign in_store  = (IW'(in_row) < IW'(MAX_NODES)) && (IW'(in_col) < IW'(MAX_NODES));
  assign m_tdata   = {7'd0, out_flag};
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (node_count == '0) begin
      used_n = (NW + 1)'(1);
    end else if (IW'(node_count) > IW'(MAX_NODES)) begin
      used_n = (NW + 1)'(MAX_NODES);
    end else begin
      used_n = (NW + 1)'(node_count);
    end
  end

  assign cell_we = in_fire && in_store;
  assign cell_wa = {NW'(in_row), NW'(in_col)};
  assign cell_ra = {cur_node, cur_next[NW-1:0]};

  assign scan_end    = (cur_next >= n_q);
  assign hit         = cell_rd[0] && !(cur_hasp && (col_q == cur_parent));
  assign cycle_found = visited[col_q] || (sp == (NW + 1)'(MAX_NODES));

  assign stk_we = (state == ST_CHECK) && hit && !cycle_found;
  assign stk_wa = NW'(sp - (NW + 1)'(1));
  assign stk_wd = {cur_next, cur_hasp, cur_parent, cur_node};
  assign stk_ra = NW'(sp - (NW + 1)'(2));

  gtc_ram #(
    .DEPTH (CDEP),
    .WIDTH (1)
  ) u_cells (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_wa),
    .wr_data (in_edge),
    .rd_addr (cell_ra),
    .rd_data (cell_rd)
  );

  gtc_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (FW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_wa),
    .wr_data (stk_wd),
    .rd_addr (stk_ra),
    .rd_data (stk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && s_tlast) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: state_next = ST_SCAN;
      ST_SCAN: begin
        if (!scan_end) begin
          state_next = ST_CHECK;
        end else if (sp == (NW + 1)'(1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_CHECK: begin
        if (hit && cycle_found) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_POP: state_next = ST_SCAN;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      visited    <= '0;
      sp         <= '0;
      seen       <= '0;
      m_tvalid   <= 1'b0;
      out_flag   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
        out_flag <= result_q;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          n_q        <= used_n;
          visited    <= MAX_NODES'(1);
          seen       <= (NW + 1)'(1);
          sp         <= (NW + 1)'(1);
          cur_node   <= '0;
          cur_parent <= '0;
          cur_hasp   <= 1'b0;
          cur_next   <= '0;
        end
        ST_SCAN: begin
          if (!scan_end) begin
            col_q    <= cur_next[NW-1:0];
            cur_next <= cur_next + (NW + 1)'(1);
          end else if (sp == (NW + 1)'(1)) begin
            result_q <= (seen == n_q);
          end else begin
            sp <= sp - (NW + 1)'(1);
          end
        end
        ST_CHECK: begin
          if (hit) begin
            if (cycle_found) begin
              result_q <= 1'b0;
            end else begin
              visited[col_q] <= 1'b1;
              seen           <= seen + (NW + 1)'(1);
              sp             <= sp + (NW + 1)'(1);
              cur_node       <= col_q;
              cur_parent     <= cur_node;
              cur_hasp       <= 1'b1;
              cur_next       <= '0;
            end
          end
        end
        ST_POP: begin
          {cur_next, cur_hasp, cur_parent, cur_node} <= stk_rd;
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/tree_verdict_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_verdict_checker
// Watches the config, cell and result channels of graph_tree_check. Keeps its
// own copy of the adjacency matrix and node count, runs the depth-first walk
// on every last cell and compares each result transfer with the oldest
// predicted tree flag. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module tree_verdict_checker import gtc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [15:0]        s_tdata,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [7:0]         m_tdata,
  output int                 fail_count,
  output int                 pending
);

  localparam int NODE_W = $clog2(MAX_NODES);

  typedef struct {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;
    logic              has_parent;
    logic [NODE_W:0]   next_col;
  } walk_frame_t;

  logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
  logic [COUNT_W-1:0]   node_count;
  logic                 tree_flags_q [$];
  logic                 want_flag;

  task automatic report_mismatch(input string what);
    fail_count = fail_count + 1;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic logic walk_is_tree();
    walk_frame_t          stack [MAX_NODES];
    logic [MAX_NODES-1:0] seen;
    int                   sp;
    int                   n;
    int                   col;
    int                   top;
    if (node_count == 0) n = 1;
    else if (node_count > MAX_NODES) n = MAX_NODES;
    else n = int'(node_count);
    seen                = '0;
    seen[0]             = 1'b1;
    stack[0].node       = '0;
    stack[0].parent     = '0;
    stack[0].has_parent = 1'b0;
    stack[0].next_col   = '0;
    sp = 1;
    while (sp > 0) begin
      top = sp - 1;
      if (stack[top].next_col >= n) begin
        sp = sp - 1;
        continue;
      end
      col = int'(stack[top].next_col);
      stack[top].next_col = stack[top].next_col + 1'b1;
      if (!adj_rows[stack[top].node][col]) continue;
      // the edge back to the parent is not a cycle
      if (stack[top].has_parent && col == stack[top].parent) continue;
      if (seen[col]) return 1'b0;
      seen[col] = 1'b1;
      if (sp >= MAX_NODES) return 1'b0;
      stack[sp].node       = NODE_W'(col);
      stack[sp].parent     = stack[top].node;
      stack[sp].has_parent = 1'b1;
      stack[sp].next_col   = '0;
      sp = sp + 1;
    end
    for (int v = 0; v < n; v++)
      if (!seen[v]) return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      node_count = NODE_COUNT_RESET;
      for (int i = 0; i < MAX_NODES; i++) adj_rows[i] = '0;
      tree_flags_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) node_count = cfg_data;
      if (s_tvalid && s_tready) begin
        adj_rows[s_tdata[5:0]][s_tdata[11:6]] = s_tdata[12];
        if (s_tlast) tree_flags_q = {tree_flags_q, walk_is_tree()};
      end
      if (m_tvalid && m_tready) begin
        if (tree_flags_q.size() == 0) begin
          report_mismatch($sformatf("result transfer is_tree=%b with none pending", m_tdata[0]));
        end else begin
          want_flag = tree_flags_q.pop_front();
          if (m_tdata[0] !== want_flag)
            report_mismatch($sformatf("is_tree got %b, want %b", m_tdata[0], want_flag));
        end
      end
    end
    pending <= tree_flags_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives graph_tree_check with directed matrices (self loop, lopsided rows,
// node counts 0, 1, 2, 3, 64, 127, cells outside the node count), one full
// 16-node tree over the corner used later, then random data sets: random trees,
// each plain or given an extra edge, a cut edge or a one-way edge with equal odds, plus
// random cell edits. Both sides stall at random; the checker compares results.
// ----------------------------------------------------------------------------
module testbench import gtc_pkg::*;;

  localparam int NODES       = MAX_NODES_DEF;
  localparam int CORNER      = 16;
  localparam int RAND_ITEMS  = 600;
  localparam int LONG_HOLD   = 2500;
  localparam int IDLE_GAP    = 4;
  localparam int LATENCY_MAX = 2 * NODES * NODES + 2 * NODES + 3;

  typedef enum int {
    GRAPH_TREE,
    GRAPH_EXTRA,
    GRAPH_CUT,
    GRAPH_ONE_WAY
  } graph_mode_t;

  typedef struct {
    int   row;
    int   col;
    logic edge_on;
  } cell_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [15:0]        s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [7:0]         m_tdata;

  int fail_count;
  int pending;
  int hold_req;
  bit quiet;
  bit tx_calm;
  int items_sent;

  logic [NODES-1:0] cell_img [NODES];
  logic [NODES-1:0] want_img [NODES];

  graph_tree_check #(.MAX_NODES(NODES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  tree_verdict_checker #(.MAX_NODES(NODES)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit: reports TEST FAILED and stops a run that hangs
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int hold_seen;
    hold_seen = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_seen = hold_seen + 1;
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_cell(input int r, input int c, input logic e, input logic l);
    if (!quiet && !tx_calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, e, 6'(c), 6'(r)};
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    cell_img[r][c] = e;
    items_sent = items_sent + 1;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random tree over n nodes in the n x n corner, then one optional defect
  task automatic build_graph(input int n, input graph_mode_t mode);
    int perm [NODES];
    int eu [NODES];
    int ev [NODES];
    int i;
    int j;
    int t;
    int u;
    int v;
    for (i = 0; i < NODES; i++) want_img[i] = cell_img[i];
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++) want_img[i][j] = 1'b0;
    for (i = 0; i < n; i++) perm[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 1; i < n; i++) begin
      j = $urandom_range(0, i - 1);
      eu[i] = perm[i];
      ev[i] = perm[j];
      want_img[eu[i]][ev[i]] = 1'b1;
      want_img[ev[i]][eu[i]] = 1'b1;
    end
    case (mode)
      GRAPH_EXTRA: begin
        u = $urandom_range(0, n - 1);
        v = $urandom_range(0, n - 1);
        want_img[u][v] = 1'b1;
        want_img[v][u] = 1'b1;
      end
      GRAPH_CUT: begin
        if (n > 1) begin
          i = $urandom_range(1, n - 1);
          want_img[eu[i]][ev[i]] = 1'b0;
          want_img[ev[i]][eu[i]] = 1'b0;
        end
      end
      GRAPH_ONE_WAY: begin
        if (n > 1) begin
          i = $urandom_range(1, n - 1);
          if ($urandom_range(0, 1)) want_img[eu[i]][ev[i]] = 1'b0;
          else want_img[ev[i]][eu[i]] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // sends only the cells that differ from what the block holds, shuffled,
  // with some noise outside the node count, then the last cell
  task automatic send_diffs(input int n);
    cell_t pend [$];
    cell_t entry;
    cell_t tmp;
    int    i;
    int    j;
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++)
        if (want_img[i][j] != cell_img[i][j]) begin
          entry.row     = i;
          entry.col     = j;
          entry.edge_on = want_img[i][j];
          pend = {pend, entry};
        end
    repeat ($urandom_range(0, 3)) begin
      entry.row     = $urandom_range(0, NODES - 1);
      entry.col     = $urandom_range(0, NODES - 1);
      entry.edge_on = 1'($urandom_range(0, 1));
      if (entry.row >= n || entry.col >= n) pend = {pend, entry};
    end
    for (i = pend.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pend[i];
      pend[i] = pend[j];
      pend[j] = tmp;
    end
    foreach (pend[k]) send_cell(pend[k].row, pend[k].col, pend[k].edge_on, 1'b0);
    i = $urandom_range(0, n - 1);
    j = $urandom_range(0, n - 1);
    send_cell(i, j, want_img[i][j], 1'b1);
  endtask

  initial begin : stimulus
    int                 r;
    int                 c;
    int                 sel;
    int                 eff;
    int                 rand_start;
    int                 pressure_left;
    bit                 pressure_done;
    logic [COUNT_W-1:0] n;

    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    hold_req      = 0;
    quiet         = 1'b0;
    tx_calm       = 1'b0;
    items_sent    = 0;
    pressure_left = 0;
    pressure_done = 1'b0;
    eff           = 1;
    for (r = 0; r < NODES; r++) cell_img[r] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // node count at reset is 1: empty node, then self loop
    send_cell(0, 0, 1'b0, 1'b1);
    send_cell(0, 0, 1'b1, 1'b1);
    // node count 0 acts as 1
    cfg_write(7'd0);
    send_cell(0, 0, 1'b0, 1'b1);
    // two nodes: symmetric edge, then one-way, then disconnected
    cfg_write(7'd2);
    send_cell(0, 0, 1'b0, 1'b0);
    send_cell(0, 1, 1'b1, 1'b0);
    send_cell(1, 0, 1'b1, 1'b0);
    send_cell(1, 1, 1'b0, 1'b1);
    send_cell(1, 0, 1'b0, 1'b1);
    send_cell(0, 1, 1'b0, 1'b1);
    // cells outside the node count, then a triangle
    send_cell(63, 63, 1'b1, 1'b0);
    send_cell(63, 0, 1'b0, 1'b0);
    send_cell(0, 63, 1'b1, 1'b1);
    cfg_write(7'd3);
    send_cell(0, 1, 1'b1, 1'b0);
    send_cell(1, 0, 1'b1, 1'b0);
    send_cell(0, 2, 1'b1, 1'b0);
    send_cell(2, 0, 1'b1, 1'b0);
    send_cell(1, 2, 1'b1, 1'b0);
    send_cell(2, 1, 1'b1, 1'b0);
    send_cell(2, 2, 1'b0, 1'b1);

    // all 64 nodes in use: only rows 0 and 1 are reached, joined by one edge
    cfg_write(7'd64);
    for (r = 0; r < 2; r++)
      for (c = 0; c < NODES; c++)
        send_cell(r, c, (r + c == 1), (r == 1) && (c == NODES - 1));
    // node count above the store saturates
    cfg_write(7'd127);
    send_cell(1, 0, 1'b1, 1'b1);

    // full tree over the corner; afterwards every cell there has been written
    cfg_write(7'(CORNER));
    build_graph(CORNER, GRAPH_TREE);
    for (r = 0; r < CORNER; r++)
      for (c = 0; c < CORNER; c++)
        send_cell(r, c, want_img[r][c], (r == CORNER - 1) && (c == CORNER - 1));

    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      if (items_sent - rand_start > RAND_ITEMS - 150) quiet <= 1'b1;
      if (!pressure_done && items_sent - rand_start > 300) begin
        // hold results off while several data sets queue up behind them
        hold_req      <= hold_req + 1;
        pressure_left = 4;
        pressure_done = 1'b1;
      end
      if (pressure_left > 0) begin
        pressure_left = pressure_left - 1;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 75) n = COUNT_W'($urandom_range(1, 8));
        else if (sel < 97) n = COUNT_W'($urandom_range(9, CORNER));
        else n = '0;
        cfg_write(n);
        if (n == '0) eff = 1;
        else eff = int'(n);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        build_graph(eff, graph_mode_t'($urandom_range(0, 3)));
        send_diffs(eff);
      end else begin
        repeat ($urandom_range(0, 12))
          send_cell($urandom_range(0, 63), $urandom_range(0, 63),
                    1'($urandom_range(0, 1)), 1'b0);
        send_cell($urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)), 1'b1);
      end
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY_MAX) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
